>>> rtl/esc_pkg.sv
// shared types, character codes and helper functions of the expression syntax checker
package esc_pkg;

	typedef enum logic [2:0] {
		ERR_OK      = 3'd0,
		ERR_DOT     = 3'd1,
		ERR_CLOSE   = 3'd2,
		ERR_OPER    = 3'd3,
		ERR_CHAR    = 3'd4,
		ERR_UNBAL   = 3'd5,
		ERR_FUNC    = 3'd6,
		ERR_VAR     = 3'd7
	} err_t;

	typedef struct packed {
		logic       in_number;
		logic       in_variable;
		logic       point_seen;
		logic       expect_open_paren;
		logic [7:0] prev_char;
		err_t       first_error;
	} state_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_CARET  = 8'h5e;
	localparam logic [7:0] CH_MOD    = 8'h6d;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_UC_C   = 8'h43;
	localparam logic [7:0] CH_UC_S   = 8'h53;
	localparam logic [7:0] CH_UC_T   = 8'h54;
	localparam logic [7:0] CH_LC_C   = 8'h63;
	localparam logic [7:0] CH_LC_S   = 8'h73;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_SQRT   = 8'h71;
	localparam logic [7:0] CH_LN     = 8'h6e;
	localparam logic [7:0] CH_LOG    = 8'h67;

	function automatic logic is_arith(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_SLASH || c == CH_STAR ||
			c == CH_CARET;
	endfunction

	function automatic logic is_operator(input logic [7:0] c);
		return is_arith(c) || c == CH_MOD;
	endfunction

	function automatic logic is_function(input logic [7:0] c);
		return c == CH_UC_C || c == CH_UC_S || c == CH_UC_T || c == CH_LC_C ||
			c == CH_LC_S || c == CH_LC_T || c == CH_SQRT || c == CH_LN ||
			c == CH_LOG;
	endfunction

endpackage

>>> rtl/esc_step.sv
// next-state and error logic for one character of the expression
module esc_step #(
	parameter int DEPTH_BITS = 8
) (
	input  esc_pkg::state_t        st,
	input  logic [DEPTH_BITS-1:0]  depth,
	input  logic [7:0]             ch,
	input  logic                   last,
	output esc_pkg::state_t        st_next,
	output logic [DEPTH_BITS-1:0]  depth_next
);

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

	esc_pkg::err_t err;
	logic          prev_ok;

	assign prev_ok = st.prev_char == esc_pkg::CH_LPAREN || esc_pkg::is_arith(st.prev_char) ||
		st.prev_char == esc_pkg::CH_NUL;

	always_comb begin
		st_next    = st;
		depth_next = depth;
		err        = esc_pkg::ERR_OK;
		if (st.first_error == esc_pkg::ERR_OK) begin
			if (st.expect_open_paren && ch != esc_pkg::CH_LPAREN) begin
				err = esc_pkg::ERR_FUNC;
			end else begin
				st_next.expect_open_paren = 1'b0;
				priority if (ch >= esc_pkg::CH_0 && ch <= esc_pkg::CH_9) begin
					if (st.in_variable) err = esc_pkg::ERR_VAR;
					else st_next.in_number = 1'b1;
				end else if (ch == esc_pkg::CH_DOT) begin
					if (st.point_seen || st.in_variable) err = esc_pkg::ERR_DOT;
					else st_next.point_seen = 1'b1;
				end else if (ch == esc_pkg::CH_LPAREN) begin
					if (st.in_variable) begin
						err = esc_pkg::ERR_VAR;
					end else if (depth == DEPTH_MAX) begin
						err = esc_pkg::ERR_UNBAL;
					end else begin
						depth_next        = depth + 1'b1;
						st_next.in_number = 1'b0;
					end
				end else if (ch == esc_pkg::CH_RPAREN) begin
					if (depth == '0 || st.prev_char == esc_pkg::CH_LPAREN) begin
						err = esc_pkg::ERR_CLOSE;
					end else begin
						depth_next        = depth - 1'b1;
						st_next.in_number = 1'b0;
					end
				end else if (esc_pkg::is_operator(ch)) begin
					if (!st.in_number && st.prev_char != esc_pkg::CH_RPAREN &&
						st.prev_char != esc_pkg::CH_X) begin
						err = esc_pkg::ERR_OPER;
					end else begin
						st_next.in_number   = 1'b0;
						st_next.in_variable = 1'b0;
					end
				end else if (esc_pkg::is_function(ch)) begin
					if (!prev_ok || last) begin
						err = esc_pkg::ERR_FUNC;
					end else begin
						st_next.expect_open_paren = 1'b1;
						st_next.in_number         = 1'b0;
					end
				end else if (ch == esc_pkg::CH_X) begin
					if (st.in_number || st.prev_char == esc_pkg::CH_RPAREN ||
						st.prev_char == esc_pkg::CH_X) begin
						err = esc_pkg::ERR_VAR;
					end else begin
						st_next.in_variable = 1'b1;
						st_next.in_number   = 1'b0;
					end
				end else begin
					err = esc_pkg::ERR_CHAR;
				end
			end
			if (err == esc_pkg::ERR_OK) begin
				if (!st_next.in_number) st_next.point_seen = 1'b0;
				st_next.prev_char = ch;
			end
			st_next.first_error = err;
		end
	end

endmodule

>>> rtl/expression_syntax_checker.sv
// top level of the expression syntax checker: input stage, state registers, result register
// the last character is registered in the input stage, then its code in the result register
// throughput: one character per cycle, but for the stall below; esc_step is combinational
// a waiting result stalls only a last character in the input stage until it is transferred
// reset: arst_n clears all valid flags and the checker state, ready for a new expression
// after each last character the state returns to its reset value
module expression_syntax_checker #(
	parameter int DEPTH_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,   // last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [2:0] error_code, [7:3] zero
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic                  adv_s1;
	esc_pkg::state_t       st_q;
	esc_pkg::state_t       st_next;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [DEPTH_BITS-1:0] depth_next;
	logic                  m_valid_q;
	esc_pkg::err_t         code_q;
	esc_pkg::err_t         code;

	assign adv_s1   = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	esc_step #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_step (
		.st         (st_q),
		.depth      (depth_q),
		.ch         (ch_s1),
		.last       (last_s1),
		.st_next    (st_next),
		.depth_next (depth_next)
	);

	always_comb begin
		code = st_next.first_error;
		if (code == esc_pkg::ERR_OK && depth_next != '0) code = esc_pkg::ERR_UNBAL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			depth_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				st_q    <= '0;
				depth_q <= '0;
			end else begin
				st_q    <= st_next;
				depth_q <= depth_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			code_q <= code;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, code_q};

	// state is back at reset after the last character of an expression
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> st_q == '0 && depth_q == '0)
		else $error("state not cleared after last character");

	// a latched error holds until the expression ends
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.first_error != esc_pkg::ERR_OK && !(adv_s1 && last_s1)
		|=> st_q.first_error == $past(st_q.first_error))
		else $error("latched error changed inside an expression");

	// a pending open paren always follows an accepted function letter
	a_expect_func: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.expect_open_paren |-> esc_pkg::is_function(st_q.prev_char))
		else $error("open paren expected without a function letter");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_tready |-> !(adv_s1 && last_s1))
		else $error("result overwritten before transfer");

endmodule

>>> test/tb.sv
// testbench for expression_syntax_checker: directed rows, deep nesting and random expressions
module tb;

	localparam int DEPTH_BITS   = 8;
	localparam int DEPTH_TOP    = (1 << DEPTH_BITS) - 1;
	localparam int RANDOM_ITEMS = 620;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_AT      = 900;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [7:0]    ch;
		logic          last;
		logic          typed;
		esc_pkg::err_t code;
	} stim_t;

	typedef enum int {SINK_OPEN, SINK_COIN, SINK_THIRD, SINK_SPARSE} sink_mode_t;

	localparam stim_t DIRECTED_ROWS [24] = '{
		'{esc_pkg::CH_0,      1'b1, 1'b1, esc_pkg::ERR_OK},
		'{esc_pkg::CH_NUL,    1'b1, 1'b1, esc_pkg::ERR_CHAR},
		'{8'hff,              1'b1, 1'b1, esc_pkg::ERR_CHAR},
		'{esc_pkg::CH_LC_S,   1'b1, 1'b1, esc_pkg::ERR_FUNC},
		'{esc_pkg::CH_LPAREN, 1'b1, 1'b1, esc_pkg::ERR_UNBAL},
		'{esc_pkg::CH_RPAREN, 1'b1, 1'b1, esc_pkg::ERR_CLOSE},
		'{esc_pkg::CH_PLUS,   1'b1, 1'b1, esc_pkg::ERR_OPER},
		'{esc_pkg::CH_9,      1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_DOT,    1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_DOT,    1'b1, 1'b1, esc_pkg::ERR_DOT},
		'{esc_pkg::CH_X,      1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_9,      1'b1, 1'b1, esc_pkg::ERR_VAR},
		'{esc_pkg::CH_LOG,    1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_0,      1'b1, 1'b1, esc_pkg::ERR_FUNC},
		'{esc_pkg::CH_LPAREN, 1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_RPAREN, 1'b1, 1'b1, esc_pkg::ERR_CLOSE},
		'{esc_pkg::CH_MINUS,  1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_0,      1'b1, 1'b1, esc_pkg::ERR_OPER},
		'{esc_pkg::CH_SQRT,   1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_LPAREN, 1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_X,      1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_RPAREN, 1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_MOD,    1'b0, 1'b0, esc_pkg::ERR_OK},
		'{esc_pkg::CH_0,      1'b1, 1'b0, esc_pkg::ERR_OK}
	};

	localparam logic [7:0] FUNC_CHARS [9] = '{esc_pkg::CH_UC_C, esc_pkg::CH_UC_S,
		esc_pkg::CH_UC_T, esc_pkg::CH_LC_C, esc_pkg::CH_LC_S, esc_pkg::CH_LC_T,
		esc_pkg::CH_SQRT, esc_pkg::CH_LN, esc_pkg::CH_LOG};
	localparam logic [7:0] OPER_CHARS [6] = '{esc_pkg::CH_PLUS, esc_pkg::CH_MINUS,
		esc_pkg::CH_SLASH, esc_pkg::CH_STAR, esc_pkg::CH_CARET, esc_pkg::CH_MOD};
	localparam logic [7:0] SYNTAX_CHARS [8] = '{esc_pkg::CH_DOT, esc_pkg::CH_LPAREN,
		esc_pkg::CH_RPAREN, esc_pkg::CH_X, esc_pkg::CH_0, esc_pkg::CH_PLUS, esc_pkg::CH_MOD,
		esc_pkg::CH_LC_S};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;

	logic          cur_typed;
	esc_pkg::err_t cur_code;

	stim_t         stim_q[$];
	esc_pkg::err_t codes_due[$];

	int chars_taken  = 0;
	int exprs_taken  = 0;
	int codes_seen   = 0;
	int failures     = 0;
	int idle_cycles  = 0;
	int random_exprs = 0;

	// predictor state
	logic                  p_in_num;
	logic                  p_in_var;
	logic                  p_point;
	logic [DEPTH_BITS-1:0] p_depth;
	logic [7:0]            p_prev;
	logic                  p_expect_paren;
	esc_pkg::err_t         p_first;

	expression_syntax_checker #(.DEPTH_BITS(DEPTH_BITS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic void clear_predictor();
		p_in_num       = 1'b0;
		p_in_var       = 1'b0;
		p_point        = 1'b0;
		p_depth        = '0;
		p_prev         = esc_pkg::CH_NUL;
		p_expect_paren = 1'b0;
		p_first        = esc_pkg::ERR_OK;
	endfunction

	function automatic esc_pkg::err_t char_error(input logic [7:0] c, input logic is_last);
		logic prev_ok;
		if (p_expect_paren) begin
			if (c != esc_pkg::CH_LPAREN) return esc_pkg::ERR_FUNC;
			p_expect_paren = 1'b0;
		end
		if (c >= esc_pkg::CH_0 && c <= esc_pkg::CH_9) begin
			if (p_in_var) return esc_pkg::ERR_VAR;
			p_in_num = 1'b1;
		end else begin
			case (c)
				esc_pkg::CH_DOT: begin
					if (p_point || p_in_var) return esc_pkg::ERR_DOT;
					p_point = 1'b1;
				end
				esc_pkg::CH_LPAREN: begin
					if (p_in_var) return esc_pkg::ERR_VAR;
					if (p_depth == '1) return esc_pkg::ERR_UNBAL;
					p_depth  = p_depth + 1'b1;
					p_in_num = 1'b0;
				end
				esc_pkg::CH_RPAREN: begin
					if (p_depth == '0 || p_prev == esc_pkg::CH_LPAREN) return esc_pkg::ERR_CLOSE;
					p_depth  = p_depth - 1'b1;
					p_in_num = 1'b0;
				end
				esc_pkg::CH_PLUS, esc_pkg::CH_MINUS, esc_pkg::CH_SLASH, esc_pkg::CH_STAR,
				esc_pkg::CH_CARET, esc_pkg::CH_MOD: begin
					if (!p_in_num && p_prev != esc_pkg::CH_RPAREN && p_prev != esc_pkg::CH_X)
						return esc_pkg::ERR_OPER;
					p_in_num = 1'b0;
					p_in_var = 1'b0;
				end
				esc_pkg::CH_UC_C, esc_pkg::CH_UC_S, esc_pkg::CH_UC_T, esc_pkg::CH_LC_C,
				esc_pkg::CH_LC_S, esc_pkg::CH_LC_T, esc_pkg::CH_SQRT, esc_pkg::CH_LN,
				esc_pkg::CH_LOG: begin
					prev_ok = p_prev == esc_pkg::CH_LPAREN || p_prev == esc_pkg::CH_PLUS ||
						p_prev == esc_pkg::CH_MINUS || p_prev == esc_pkg::CH_SLASH ||
						p_prev == esc_pkg::CH_STAR || p_prev == esc_pkg::CH_CARET ||
						p_prev == esc_pkg::CH_NUL;
					if (!prev_ok || is_last) return esc_pkg::ERR_FUNC;
					p_expect_paren = 1'b1;
					p_in_num       = 1'b0;
				end
				esc_pkg::CH_X: begin
					if (p_in_num || p_prev == esc_pkg::CH_RPAREN || p_prev == esc_pkg::CH_X)
						return esc_pkg::ERR_VAR;
					p_in_var = 1'b1;
					p_in_num = 1'b0;
				end
				default: return esc_pkg::ERR_CHAR;
			endcase
		end
		if (!p_in_num) p_point = 1'b0;
		p_prev = c;
		return esc_pkg::ERR_OK;
	endfunction

	task automatic take_char(input logic [7:0] c, input logic is_last, input logic typed,
		input esc_pkg::err_t code);
		esc_pkg::err_t res;
		if (p_first == esc_pkg::ERR_OK) p_first = char_error(c, is_last);
		if (is_last) begin
			res = p_first;
			if (res == esc_pkg::ERR_OK && p_depth != '0) res = esc_pkg::ERR_UNBAL;
			codes_due.push_back(typed ? code : res);
			clear_predictor();
		end
	endtask

	task automatic push_expression(input logic [7:0] e[$]);
		foreach (e[k])
			stim_q.push_back('{e[k], logic'(k == e.size() - 1), 1'b0, esc_pkg::ERR_OK});
	endtask

	task automatic note_failure(input string msg);
		if (failures < 10) $display("mismatch at %0t: %s", $realtime, msg);
		failures++;
	endtask

	always @(posedge clk) begin : scoreboard
		esc_pkg::err_t due;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				take_char(s_tdata, s_tlast, cur_typed, cur_code);
				chars_taken++;
				if (s_tlast) exprs_taken++;
			end
			if (m_tvalid && m_tready) begin
				codes_seen++;
				if (codes_due.size() == 0) begin
					note_failure($sformatf("result 0x%02h with none expected", m_tdata));
				end else begin
					due = codes_due.pop_front();
					if (m_tdata != {5'b0, due})
						note_failure($sformatf("expected code %0d, got 0x%02h", due, m_tdata));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	initial begin : result_sink
		sink_mode_t mode;
		int         seg;
		logic       hold_done;
		hold_done = 1'b0;
		m_tready  = 1'b0;
		wait (arst_n);
		forever begin
			if (!hold_done && chars_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = sink_mode_t'($urandom_range(0, 3));
			seg  = $urandom_range(20, 200);
			for (int k = 0; k < seg; k++) begin
				case (mode)
					SINK_OPEN:  m_tready <= 1'b1;
					SINK_COIN:  m_tready <= 1'($urandom_range(0, 1));
					SINK_THIRD: m_tready <= (k % 3 == 0);
					default:    m_tready <= ($urandom_range(0, 15) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("timeout: no transfer for %0d cycles, %0d codes outstanding", IDLE_LIMIT,
			codes_due.size());
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main
		logic [7:0] e[$];
		int         rand_chars;
		int         lvl, terms, ndig, dot_at, pos, idx, burst, gap;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		cur_typed = 1'b0;
		cur_code  = esc_pkg::ERR_OK;
		clear_predictor();

		foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);

		// full depth, balanced
		e.delete();
		repeat (DEPTH_TOP) e.push_back(esc_pkg::CH_LPAREN);
		e.push_back(esc_pkg::CH_0 + 8'd7);
		repeat (DEPTH_TOP) e.push_back(esc_pkg::CH_RPAREN);
		push_expression(e);
		// one open paren past the counter range
		e.delete();
		repeat (DEPTH_TOP + 1) e.push_back(esc_pkg::CH_LPAREN);
		e.push_back(esc_pkg::CH_X);
		push_expression(e);

		rand_chars = 0;
		while (rand_chars < RANDOM_ITEMS) begin
			e.delete();
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 6)) e.push_back(8'($urandom_range(0, 255)));
			end else begin
				terms = $urandom_range(1, 6);
				lvl   = 0;
				for (int t = 0; t < terms; t++) begin
					while (lvl < 4 && $urandom_range(0, 3) == 0) begin
						if ($urandom_range(0, 1)) e.push_back(FUNC_CHARS[$urandom_range(0, 8)]);
						e.push_back(esc_pkg::CH_LPAREN);
						lvl++;
					end
					if ($urandom_range(0, 3) == 0) begin
						e.push_back(esc_pkg::CH_X);
					end else begin
						ndig   = $urandom_range(1, 3);
						dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ndig) : -1;
						for (int k = 0; k <= ndig; k++) begin
							if (k == dot_at) e.push_back(esc_pkg::CH_DOT);
							if (k < ndig) e.push_back(esc_pkg::CH_0 + 8'($urandom_range(0, 9)));
						end
					end
					while (lvl > 0 && $urandom_range(0, 2) == 0) begin
						e.push_back(esc_pkg::CH_RPAREN);
						lvl--;
					end
					if (t < terms - 1) e.push_back(OPER_CHARS[$urandom_range(0, 5)]);
				end
				while (lvl > 0) begin
					e.push_back(esc_pkg::CH_RPAREN);
					lvl--;
				end
				// mangle about a quarter of the well-formed ones
				if ($urandom_range(0, 3) == 0) begin
					pos = $urandom_range(0, e.size() - 1);
					case ($urandom_range(0, 3))
						0: e[pos] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
							SYNTAX_CHARS[$urandom_range(0, 7)];
						1: e.delete(pos);
						2: e.insert(pos, e[pos]);
						default: while (e.size() > pos + 1) void'(e.pop_back());
					endcase
					if (e.size() == 0) e.push_back(esc_pkg::CH_X);
				end
			end
			rand_chars += e.size();
			random_exprs++;
			push_expression(e);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		idx = 0;
		while (idx < stim_q.size()) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && idx < stim_q.size()) begin
				s_tvalid  <= 1'b1;
				s_tdata   <= stim_q[idx].ch;
				s_tlast   <= stim_q[idx].last;
				cur_typed <= stim_q[idx].typed;
				cur_code  <= stim_q[idx].code;
				do @(posedge clk); while (!s_tready);
				idx++;
				burst--;
			end
			case ($urandom_range(0, 7))
				0, 1:    gap = 0;
				2:       gap = $urandom_range(10, 30);
				default: gap = $urandom_range(1, 3);
			endcase
			if (gap > 0 && idx < stim_q.size()) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;

		while (codes_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d characters in %0d expressions (directed rows, full and overflowed",
			chars_taken, exprs_taken);
		$display("nesting, %0d random or mangled), %0d codes compared, %0d failures",
			random_exprs, codes_seen, failures);
		if (failures == 0 && codes_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/esc_pkg.sv
rtl/esc_step.sv
rtl/expression_syntax_checker.sv
test/tb.sv
